[rtl/hcs_pkg.sv]
// shared types and constants for the hashed counter sketch update core
package hcs_pkg;

  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 32;
  localparam int RIDX_W     = 10;
  localparam int NUMCOL_W   = 11;
  localparam int SEED_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COL_W_MAX  = 16;
  localparam int HASH_W     = 34;
  localparam int PROD_W     = 64;
  localparam int HALF_W     = 16;
  localparam int FOLD_SHIFT = 31;
  localparam int FIX_ROUNDS = 3;
  localparam int HASH_STAGES = 3;

  localparam logic [HASH_W-1:0]   MERSENNE_P   = 34'h0_7FFF_FFFF;
  localparam logic [NUMCOL_W-1:0] NUMCOL_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_A,
    REG_SEED_B1,
    REG_SEED_B2,
    REG_SEED_B3,
    REG_NUM_COLUMNS
  } reg_index_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  // one classified beat waiting between front and back
  typedef struct packed {
    action_t             action;
    logic [KEY_W-1:0]    key;
    logic [RIDX_W-1:0]   read_index;
    logic                ridx_ok;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic                 done;
    logic [COL_W_MAX-1:0] col;
  } hash_rsp_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_MUL_LO,
    H_MUL_HI,
    H_FOLD,
    H_FIX,
    H_DIV,
    H_DONE
  } hash_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_HASH,
    B_INC,
    B_RDWAIT,
    B_RESULT
  } back_state_t;

endpackage

[rtl/hcs_front.sv]
// front end: accepts input beats, classifies them and queues them for the back end
module hcs_front import hcs_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              action,
  input  logic [KEY_W-1:0]  key,
  input  logic [RIDX_W-1:0] read_index,
  input  logic              clearing,
  output logic              q_valid,
  input  logic              q_pop,
  output cmd_t              q_head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       accept;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.action     = action_t'(action);
    cmd_in.key        = key;
    cmd_in.read_index = read_index;
    cmd_in.ridx_ok    = (32'(read_index) < 32'(COLUMNS));
  end

  assign full    = (fill == 2'd2) || clearing;
  assign accept  = push && !full;
  assign q_valid = (fill != 2'd0);
  assign q_head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      case ({accept, q_pop && q_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/hcs_hash.sv]
// iterative polynomial hash over 2^31-1 followed by a bit-serial column reduction
module hcs_hash import hcs_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SEED_W-1:0]   seed_a,
  input  logic [SEED_W-1:0]   seed_b1,
  input  logic [SEED_W-1:0]   seed_b2,
  input  logic [SEED_W-1:0]   seed_b3,
  input  logic [NUMCOL_W-1:0] num_columns,
  input  hash_req_t           req,
  output hash_rsp_t           rsp
);

  localparam int MW = $clog2(COLUMNS + 1);

  hash_state_t state;
  hash_state_t state_next;

  logic [KEY_W-1:0]  key_r;
  logic [HASH_W-1:0] acc;
  logic [PROD_W-1:0] prod;
  logic [1:0]        stage_cnt;
  logic [1:0]        fix_cnt;
  logic [5:0]        div_cnt;
  logic [MW-1:0]     rem;

  logic [MW-1:0]          modulus;
  logic [HALF_W-1:0]      key_half;
  logic [HASH_W+HALF_W-1:0] pp;
  logic [SEED_W-1:0]      seed_add;
  logic [HASH_W-1:0]      folded;
  logic [MW:0]            trial;
  logic                   trial_ge;

  // out-of-range column counts fall back to the full table
  assign modulus = (num_columns == '0 || 32'(num_columns) > 32'(COLUMNS)) ?
                   MW'(COLUMNS) : MW'(num_columns);

  always_comb begin
    key_half = (state == H_MUL_HI) ? key_r[KEY_W-1:HALF_W] : key_r[HALF_W-1:0];
    pp       = acc * key_half;
    case (stage_cnt)
      2'd0:    seed_add = seed_b1;
      2'd1:    seed_add = seed_b2;
      default: seed_add = seed_b3;
    endcase
    folded   = {1'b0, prod[PROD_W-1:FOLD_SHIFT]} +
               {3'b000, prod[FOLD_SHIFT-1:0]};
    trial    = {rem, acc[HASH_W-1]};
    trial_ge = (trial >= {1'b0, modulus});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      H_IDLE:   if (req.start) state_next = H_MUL_LO;
      H_MUL_LO: state_next = H_MUL_HI;
      H_MUL_HI: state_next = H_FOLD;
      H_FOLD:   state_next = H_FIX;
      H_FIX: begin
        if (fix_cnt == 2'(FIX_ROUNDS - 1)) begin
          state_next = (stage_cnt == 2'(HASH_STAGES - 1)) ? H_DIV : H_MUL_LO;
        end
      end
      H_DIV:    if (div_cnt == 6'(HASH_W - 1)) state_next = H_DONE;
      H_DONE:   state_next = H_IDLE;
      default:  state_next = H_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == H_DONE);
    rsp.col  = COL_W_MAX'(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_cnt <= 2'd0;
      fix_cnt   <= 2'd0;
      div_cnt   <= 6'd0;
    end else begin
      case (state)
        H_IDLE: begin
          stage_cnt <= 2'd0;
          fix_cnt   <= 2'd0;
          div_cnt   <= 6'd0;
        end
        H_FIX: begin
          if (fix_cnt == 2'(FIX_ROUNDS - 1)) begin
            fix_cnt   <= 2'd0;
            stage_cnt <= stage_cnt + 2'd1;
          end else begin
            fix_cnt <= fix_cnt + 2'd1;
          end
        end
        H_DIV:   div_cnt <= div_cnt + 6'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (req.start) begin
          key_r <= req.key;
          acc   <= HASH_W'(seed_a);
          rem   <= '0;
        end
      end
      // product wraps at 64 bits, seed added with the low half
      H_MUL_LO: prod <= PROD_W'(pp) + PROD_W'(seed_add);
      H_MUL_HI: prod <= prod + {pp[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
      H_FOLD:   acc  <= folded;
      H_FIX:    if (acc > MERSENNE_P) acc <= acc - MERSENNE_P;
      H_DIV: begin
        rem <= trial_ge ? MW'(trial - {1'b0, modulus}) : MW'(trial);
        acc <= {acc[HASH_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

endmodule

[rtl/hcs_back.sv]
// back end: runs queued beats against the counter memory and holds the result register
module hcs_back import hcs_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  cmd_t               q_head,
  output logic               clearing,
  output hash_req_t          hreq,
  input  hash_rsp_t          hrsp,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_count,
  input  logic               out_take
);

  localparam int IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  back_state_t state;
  back_state_t state_next;

  logic [COUNT_W-1:0] mem [COLUMNS];
  logic [COUNT_W-1:0] rdata;
  logic [IW-1:0]      clr_addr;
  logic [IW-1:0]      ins_col;
  logic               res_zero;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic               out_free;
  logic               clr_last;

  assign out_free = !out_valid || out_take;
  assign clr_last = (clr_addr == IW'(COLUMNS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_last) state_next = B_IDLE;
      B_IDLE: begin
        if (q_valid) begin
          if (q_head.action == ACT_READ) begin
            state_next = q_head.ridx_ok ? B_RDWAIT : B_RESULT;
          end else begin
            state_next = B_HASH;
          end
        end
      end
      B_HASH:   if (hrsp.done) state_next = B_INC;
      B_INC:    state_next = B_IDLE;
      B_RDWAIT: state_next = B_RESULT;
      B_RESULT: if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    clearing   = (state == B_CLEAR);
    hreq.start = 1'b0;
    hreq.key   = q_head.key;
    mem_we     = 1'b0;
    mem_waddr  = ins_col;
    mem_wdata  = rdata + COUNT_W'(1);
    mem_re     = 1'b0;
    mem_raddr  = IW'(q_head.read_index);
    unique case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.action == ACT_READ) begin
            mem_re = q_head.ridx_ok;
          end else begin
            hreq.start = 1'b1;
          end
        end
      end
      B_HASH: begin
        mem_re    = hrsp.done;
        mem_raddr = hrsp.col[IW-1:0];
      end
      B_INC:   mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (state == B_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      res_zero <= !q_head.ridx_ok;
    end
    if (state == B_HASH && hrsp.done) begin
      ins_col <= hrsp.col[IW-1:0];
    end
    if (state == B_RESULT && out_free) begin
      out_count <= res_zero ? '0 : rdata;
    end
  end

endmodule

[rtl/hashed_counter_sketch_update.sv]
// top level of the hashed counter sketch update core
//
//   channel   handshake          payload
//   input     push / full        action, key, read_index
//   result    empty / pop        count
//   config    wr_en              wr_index, wr_data
//
// an insert runs three hash rounds on a shared 34x16 multiplier, then a
// bit-serial column reduction, then a read-modify-write of the counter
// memory. a read looks up the counter at read_index; a read_index past the
// table skips the memory and returns a count of zero.
// after reset the counter memory is cleared one entry a cycle, with full held
// high. a two-beat queue lets inputs arrive while the back end works or while
// a result waits for pop.
module hashed_counter_sketch_update_core import hcs_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      action,
  input  logic [KEY_W-1:0]          key,
  input  logic [RIDX_W-1:0]         read_index,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [COUNT_W-1:0] count,
  input  logic                      wr_en,
  input  logic [CFG_IDX_W-1:0]      wr_index,
  input  logic [SEED_W-1:0]         wr_data
);

  logic [SEED_W-1:0]   seed_a;
  logic [SEED_W-1:0]   seed_b1;
  logic [SEED_W-1:0]   seed_b2;
  logic [SEED_W-1:0]   seed_b3;
  logic [NUMCOL_W-1:0] num_columns;

  logic               clearing;
  logic               q_valid;
  logic               q_pop;
  cmd_t               q_head;
  hash_req_t          hreq;
  hash_rsp_t          hrsp;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a      <= '0;
      seed_b1     <= '0;
      seed_b2     <= '0;
      seed_b3     <= '0;
      num_columns <= NUMCOL_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_SEED_A:      seed_a      <= wr_data;
        REG_SEED_B1:     seed_b1     <= wr_data;
        REG_SEED_B2:     seed_b2     <= wr_data;
        REG_SEED_B3:     seed_b3     <= wr_data;
        REG_NUM_COLUMNS: num_columns <= wr_data[NUMCOL_W-1:0];
        default: ;
      endcase
    end
  end

  hcs_front #(.COLUMNS(COLUMNS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .key        (key),
    .read_index (read_index),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_head     (q_head)
  );

  hcs_hash #(.COLUMNS(COLUMNS)) u_hash (
    .clk         (clk),
    .rst         (rst),
    .seed_a      (seed_a),
    .seed_b1     (seed_b1),
    .seed_b2     (seed_b2),
    .seed_b3     (seed_b3),
    .num_columns (num_columns),
    .req         (hreq),
    .rsp         (hrsp)
  );

  hcs_back #(.COLUMNS(COLUMNS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .clearing  (clearing),
    .hreq      (hreq),
    .hrsp      (hrsp),
    .out_valid (out_valid),
    .out_count (out_count),
    .out_take  (pop && out_valid)
  );

  assign empty = !out_valid;
  assign count = signed'(out_count);

endmodule
